// ----- hdl/osc_pkg.sv -----
// ----------------------------------------------------------------------------
// osc_pkg: shared types and constants for the slot contention resolver
// Widths, codes, divider request/response structs and sequencer states.
// ----------------------------------------------------------------------------
package osc_pkg;

  // default size of the channel busy map
  localparam int unsigned CHANNEL_COUNT_DEF = 16384;

  // field widths
  localparam int unsigned RACK_W    = 12;
  localparam int unsigned TX_W      = 3;
  localparam int unsigned OCNT_W    = 3;
  localparam int unsigned APN_W     = 16;
  localparam int unsigned REL_W     = 14;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned IN_PORT_W = 9;
  localparam int unsigned OUT_PORT_W = 10;
  localparam int unsigned CHAN_W    = 14;

  // configuration register widths
  localparam int unsigned RADIX_W = 7;
  localparam int unsigned NTX_W   = 4;
  localparam int unsigned GROUP_W = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  // internal widths: raw port sums and the unmasked channel
  localparam int unsigned PORT_RAW_W = 11;
  localparam int unsigned CHAN_RAW_W = 16;
  localparam int unsigned CMP_W      = 17;

  // shared divider
  localparam int unsigned DIVIDEND_W  = 12;
  localparam int unsigned DIVISOR_W   = 7;
  localparam int unsigned DIV_STEPS_W = $clog2(DIVIDEND_W + 1);
  localparam logic [DIV_STEPS_W-1:0] FULL_STEPS = DIV_STEPS_W'(DIVIDEND_W);
  localparam logic [DIV_STEPS_W-1:0] SLOT_STEPS = DIV_STEPS_W'(DIVISOR_W);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NTX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP = 2'd2;

  // reset values
  localparam logic [RADIX_W-1:0] RADIX_RST = 7'd4;
  localparam logic [NTX_W-1:0]   NTX_RST   = 4'd1;
  localparam logic [GROUP_W-1:0] GROUP_RST = 7'd1;

  // opcodes
  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_GRANT = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BUSY  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic                   start;
    logic [DIVIDEND_W-1:0]  dividend;
    logic [DIVISOR_W-1:0]   divisor;
    logic [DIV_STEPS_W-1:0] steps;
  } osc_div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  remainder;
  } osc_div_rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_REL,
    S_DIV_PREV,
    S_DIV_NEXT,
    S_DIV_SLOT,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_READ,
    S_RESP
  } osc_state_e;

endpackage

// ----- hdl/osc_div_unit.sv -----
// ----------------------------------------------------------------------------
// osc_div_unit: shared restoring divider
// One quotient bit per cycle; dividend is MSB aligned, steps sets its length.
// ----------------------------------------------------------------------------
module osc_div_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  osc_pkg::osc_div_req_t req_i,
  output osc_pkg::osc_div_rsp_t rsp_o
);
  import osc_pkg::*;

  logic                   run_q, run_d;
  logic                   done_q, done_d;
  logic [DIV_STEPS_W-1:0] cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0]  quo_q, quo_d;
  logic [DIVISOR_W-1:0]   rem_q, rem_d;
  logic [DIVISOR_W-1:0]   dsr_q, dsr_d;
  logic [DIVISOR_W:0]     trial;
  logic [DIVISOR_W:0]     diff;
  logic                   ge;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = req_i.steps;
      quo_d = req_i.dividend;
      rem_d = '0;
      dsr_d = req_i.divisor;
    end else if (run_q) begin
      // remainder stays below the divisor, so 7 bits hold it either way
      rem_d = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_STEPS_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ----- hdl/osc_chan_mem.sv -----
// ----------------------------------------------------------------------------
// osc_chan_mem: channel busy map
// One bit per channel, one write and one registered read port.
// ----------------------------------------------------------------------------
module osc_chan_mem #(
  parameter int unsigned DEPTH = osc_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic                     wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic                     rdata_o
);
  import osc_pkg::*;

  logic mem_q [DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/optical_switch_slot_contention.sv -----
// ----------------------------------------------------------------------------
// optical_switch_slot_contention: slot contention resolver
// Derives ports and global channel of an arrival, test-and-sets the channel
// busy bit and answers grant / retransmit / out of range; release frees a bit.
// ----------------------------------------------------------------------------
//
//  channel   signals                               handshake
//  --------  ------------------------------------  ---------------------------
//  request   start_i, busy_o, opcode_i .. rel_i    taken when start_i & !busy_o
//  result    res_valid_o, status_o .. ack_*_o      one-cycle strobe, no stall
//  config    cfg_valid_i, cfg_ready_o, idx, data   taken when valid & ready
//
// Sequence: an arrival holds busy_o high until its update is done, so no new
//   request is taken meanwhile; the result strobe is registered from the update.
//   The time is set by the shared one-bit-per-cycle divider run three times
//   (12, 12 and 7 quotient bits), then two multiply stages, a sum, a map read
//   and the update. A release makes one write to the busy map.
// Reset: after reset a sweep clears every busy map entry (CHANNEL_COUNT of them,
//   16384 at the default); busy_o stays high meanwhile. Config writes are
//   taken at any time (cfg_ready_o is always high).
// Stalls: none; the receiver takes each result in its strobe cycle.
//
module optical_switch_slot_contention #(
  parameter int unsigned CHANNEL_COUNT = osc_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                opcode_i,
  input  logic [osc_pkg::RACK_W-1:0]          source_rack_i,
  input  logic [osc_pkg::RACK_W-1:0]          dest_rack_i,
  input  logic [osc_pkg::TX_W-1:0]            transmitter_i,
  input  logic [osc_pkg::RACK_W-1:0]          group_rack_index_i,
  input  logic [osc_pkg::OCNT_W-1:0]          optical_count_i,
  input  logic [osc_pkg::APN_W-1:0]           app_packet_number_i,
  input  logic [osc_pkg::REL_W-1:0]           release_channel_i,
  // result
  output logic                                res_valid_o,
  output logic [osc_pkg::STATUS_W-1:0]        status_o,
  output logic [osc_pkg::IN_PORT_W-1:0]       input_port_o,
  output logic [osc_pkg::OUT_PORT_W-1:0]      output_port_o,
  output logic [osc_pkg::CHAN_W-1:0]          channel_index_o,
  output logic [osc_pkg::RACK_W-1:0]          ack_source_rack_o,
  output logic [osc_pkg::RACK_W-1:0]          ack_dest_rack_o,
  output logic [osc_pkg::TX_W-1:0]            ack_transmitter_o,
  output logic [osc_pkg::RACK_W-1:0]          ack_group_rack_index_o,
  output logic [osc_pkg::OCNT_W-1:0]          ack_optical_count_o,
  output logic [osc_pkg::APN_W-1:0]           ack_app_packet_number_o,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [osc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [osc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import osc_pkg::*;

  localparam int unsigned AW = $clog2(CHANNEL_COUNT);
  localparam logic [CMP_W-1:0] CHAN_LIMIT = CMP_W'(CHANNEL_COUNT);
  localparam logic [AW-1:0]    CLR_LAST   = AW'(CHANNEL_COUNT - 1);

  // --------------------------------------------------------------------------
  // configuration registers; a zero setting acts as one
  // --------------------------------------------------------------------------
  logic [RADIX_W-1:0] radix_q;
  logic [NTX_W-1:0]   ntx_q;
  logic [GROUP_W-1:0] group_q;
  logic [RADIX_W-1:0] radix_eff;
  logic [NTX_W-1:0]   ntx_eff;
  logic [GROUP_W-1:0] group_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RST;
      ntx_q   <= NTX_RST;
      group_q <= GROUP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RADIX: radix_q <= cfg_data_i[RADIX_W-1:0];
        CFG_NTX:   ntx_q   <= cfg_data_i[NTX_W-1:0];
        CFG_GROUP: group_q <= cfg_data_i[GROUP_W-1:0];
        default: begin
          // unmapped index: ignored
        end
      endcase
    end
  end

  assign radix_eff = (radix_q == '0) ? RADIX_W'(1) : radix_q;
  assign ntx_eff   = (ntx_q == '0)   ? NTX_W'(1)   : ntx_q;
  assign group_eff = (group_q == '0) ? GROUP_W'(1) : group_q;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  osc_state_e state_q, state_d;
  logic [AW-1:0] clr_cnt_q;
  logic          accept;

  osc_div_req_t div_req;
  osc_div_rsp_t div_rsp;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic          mem_re;
  logic          mem_rdata;

  // captured request
  logic [RACK_W-1:0] src_q, dst_q, gri_q;
  logic [TX_W-1:0]   tx_q;
  logic [OCNT_W-1:0] ocnt_q;
  logic [APN_W-1:0]  apn_q;
  logic [REL_W-1:0]  rel_q;

  // datapath
  logic [DIVIDEND_W-1:0] prev_quo_q;
  logic [DIVISOR_W-1:0]  prev_slot_q;
  logic [DIVISOR_W-1:0]  next_slot_q;
  logic [DIVISOR_W-1:0]  grp_quo_q;
  logic [PORT_RAW_W-1:0] in_port_q;
  logic [PORT_RAW_W-1:0] out_mul_q;
  logic [RACK_W-1:0]     cb_q;
  logic [CHAN_RAW_W-1:0] cb2_q;
  logic [PORT_RAW_W-1:0] out_port_q;
  logic [CHAN_RAW_W-1:0] chan_q;
  logic                  chan_ok_q;
  logic [CMP_W-1:0]      chan_ext;
  logic [CMP_W-1:0]      rel_ext;
  logic                  rel_ok;

  assign accept   = start_i && (state_q == S_IDLE);
  assign busy_o   = (state_q != S_IDLE);
  assign chan_ext = CMP_W'(chan_q);
  assign rel_ext  = CMP_W'(rel_q);
  assign rel_ok   = rel_ext < CHAN_LIMIT;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:    if (clr_cnt_q == CLR_LAST) state_d = S_IDLE;
      S_IDLE: begin
        if (start_i) begin
          state_d = (opcode_i == OP_RELEASE) ? S_REL : S_DIV_PREV;
        end
      end
      S_REL:      state_d = S_IDLE;
      S_DIV_PREV: if (div_rsp.done) state_d = S_DIV_NEXT;
      S_DIV_NEXT: if (div_rsp.done) state_d = S_DIV_SLOT;
      S_DIV_SLOT: if (div_rsp.done) state_d = S_MUL1;
      S_MUL1:     state_d = S_MUL2;
      S_MUL2:     state_d = S_SUM;
      S_SUM:      state_d = S_READ;
      S_READ:     state_d = S_RESP;
      S_RESP:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // divider launches and busy-map port control
  always_comb begin
    div_req   = '0;
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_q;
    mem_wdata = 1'b0;
    mem_re    = 1'b0;
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        // prev / radix
        div_req.start    = start_i && (opcode_i == OP_ARRIVAL);
        div_req.dividend = source_rack_i;
        div_req.divisor  = radix_eff;
        div_req.steps    = FULL_STEPS;
      end
      S_REL: begin
        mem_we    = rel_ok;
        mem_waddr = rel_ext[AW-1:0];
      end
      S_DIV_PREV: begin
        // next mod radix
        div_req.start    = div_rsp.done;
        div_req.dividend = dst_q;
        div_req.divisor  = radix_eff;
        div_req.steps    = FULL_STEPS;
      end
      S_DIV_NEXT: begin
        // prev_slot / group, dividend fits the divisor width: MSB-align it
        div_req.start    = div_rsp.done;
        div_req.dividend = {prev_slot_q, (DIVIDEND_W - DIVISOR_W)'(0)};
        div_req.divisor  = group_eff;
        div_req.steps    = SLOT_STEPS;
      end
      S_READ: begin
        mem_re = 1'b1;
      end
      S_RESP: begin
        // test-and-set: claim only a free, in-range channel
        mem_we    = chan_ok_q && !mem_rdata;
        mem_waddr = chan_ext[AW-1:0];
        mem_wdata = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q  <= source_rack_i;
      dst_q  <= dest_rack_i;
      tx_q   <= transmitter_i;
      gri_q  <= group_rack_index_i;
      ocnt_q <= optical_count_i;
      apn_q  <= app_packet_number_i;
      rel_q  <= release_channel_i;
    end
    case (state_q)
      S_DIV_PREV: begin
        if (div_rsp.done) begin
          prev_quo_q  <= div_rsp.quotient;
          prev_slot_q <= div_rsp.remainder;
        end
      end
      S_DIV_NEXT: if (div_rsp.done) next_slot_q <= div_rsp.remainder;
      S_DIV_SLOT: if (div_rsp.done) grp_quo_q <= div_rsp.quotient[DIVISOR_W-1:0];
      S_MUL1: begin
        in_port_q <= PORT_RAW_W'(prev_slot_q) * PORT_RAW_W'(ntx_eff) + PORT_RAW_W'(tx_q);
        out_mul_q <= PORT_RAW_W'(next_slot_q) * PORT_RAW_W'(ntx_eff);
        // (prev / radix) * radix never exceeds prev
        cb_q      <= RACK_W'(prev_quo_q * radix_eff);
      end
      S_MUL2: begin
        cb2_q      <= CHAN_RAW_W'(cb_q) * CHAN_RAW_W'(ntx_eff);
        out_port_q <= out_mul_q + PORT_RAW_W'(grp_quo_q);
      end
      S_SUM:  chan_q <= cb2_q + CHAN_RAW_W'(out_port_q);
      S_READ: chan_ok_q <= chan_ext < CHAN_LIMIT;
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // result registers
  // --------------------------------------------------------------------------
  logic                  res_valid_q;
  logic [STATUS_W-1:0]   status_q;
  logic [IN_PORT_W-1:0]  in_port_oq;
  logic [OUT_PORT_W-1:0] out_port_oq;
  logic [CHAN_W-1:0]     chan_oq;
  logic [STATUS_W-1:0]   status_d;

  always_comb begin
    if (!chan_ok_q)     status_d = STATUS_RANGE;
    else if (mem_rdata) status_d = STATUS_BUSY;
    else                status_d = STATUS_GRANT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (state_q == S_RESP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RESP) begin
      status_q    <= status_d;
      in_port_oq  <= in_port_q[IN_PORT_W-1:0];
      out_port_oq <= out_port_q[OUT_PORT_W-1:0];
      chan_oq     <= chan_q[CHAN_W-1:0];
    end
  end

  assign res_valid_o             = res_valid_q;
  assign status_o                = status_q;
  assign input_port_o            = in_port_oq;
  assign output_port_o           = out_port_oq;
  assign channel_index_o         = chan_oq;
  // echo fields hold from accept until the next accept, past the strobe
  assign ack_source_rack_o       = src_q;
  assign ack_dest_rack_o         = dst_q;
  assign ack_transmitter_o       = tx_q;
  assign ack_group_rack_index_o  = gri_q;
  assign ack_optical_count_o     = ocnt_q;
  assign ack_app_packet_number_o = apn_q;

  // --------------------------------------------------------------------------
  // shared divider and busy map
  // --------------------------------------------------------------------------
  osc_div_unit u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  osc_chan_mem #(
    .DEPTH (CHANNEL_COUNT)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (chan_ext[AW-1:0]),
    .rdata_o (mem_rdata)
  );

endmodule

// ----- hdl/osc_checker.sv -----
// ----------------------------------------------------------------------------
// osc_checker: port-level checks for the slot contention resolver
// Watches request, result and busy behavior; bound to the top level.
// ----------------------------------------------------------------------------
module osc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic                         res_valid_o,
  input logic [osc_pkg::STATUS_W-1:0] status_o
);
  import osc_pkg::*;

  // every accepted request makes the block busy in the cycle after acceptance
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request accepted but block not busy next cycle");

  // a result strobe always follows a busy cycle (final update step)
  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy_o))
    else $error("result strobe without a preceding busy cycle");

  // one result per arrival: strobes never come back to back
  a_res_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("back-to-back result strobes");

  // status is one of the three defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (status_o == STATUS_GRANT || status_o == STATUS_BUSY ||
                     status_o == STATUS_RANGE))
    else $error("undefined status code on result");

endmodule

bind optical_switch_slot_contention osc_checker u_osc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .status_o    (status_o)
);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for optical_switch_slot_contention
// A directed table covers reset values, field extremes, busy and release,
// the out-of-range channel, zero and oversized registers. Random phases
// then run arrivals and releases under several register settings. Every
// result is checked field by field against an in-bench contention predictor or a pinned row's typed-in values.
// ----------------------------------------------------------------------------
module testbench;
  import osc_pkg::*;

  localparam int unsigned CHANNELS        = CHANNEL_COUNT_DEF;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 88;
  // margin after the last result, so a trailing release can finish
  localparam int unsigned SETTLE_CYCLES   = 48;
  // watchdog bound on the whole run, clear sweep included
  localparam int unsigned CYCLE_LIMIT     = 400000;

  // index 3 maps to no register; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic                  opcode;
    logic [RACK_W-1:0]     source_rack;
    logic [RACK_W-1:0]     dest_rack;
    logic [TX_W-1:0]       transmitter;
    logic [RACK_W-1:0]     group_rack_index;
    logic [OCNT_W-1:0]     optical_count;
    logic [APN_W-1:0]      app_packet_number;
    logic [REL_W-1:0]      release_channel;
  } req_t;

  // derived part of a result, typed in for rows that read off at a glance
  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [IN_PORT_W-1:0]  input_port;
    logic [OUT_PORT_W-1:0] output_port;
    logic [CHAN_W-1:0]     channel;
  } pin_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [IN_PORT_W-1:0]  input_port;
    logic [OUT_PORT_W-1:0] output_port;
    logic [CHAN_W-1:0]     channel;
    logic [RACK_W-1:0]     source_rack;
    logic [RACK_W-1:0]     dest_rack;
    logic [TX_W-1:0]       transmitter;
    logic [RACK_W-1:0]     group_rack_index;
    logic [OCNT_W-1:0]     optical_count;
    logic [APN_W-1:0]      app_packet_number;
  } ack_t;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    req_t                   req;
    logic                   pinned;
    pin_t                   pin;
  } dir_row_t;

  localparam req_t NO_REQ = '0;
  localparam pin_t NO_PIN = '0;

  localparam int unsigned DIR_ROWS = 31;

  // Directed table. Rows with pinned=1 carry a typed-in expectation for the
  // derived fields; the rest are checked against the predictor.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // reset registers: radix 4, one transmitter, group 1
    // first arrival on channel 0 is granted, the repeat finds it busy
    '{ROW_REQ, CFG_RADIX, 7'd0,
      '{OP_ARRIVAL, 12'd0, 12'd0, 3'd0, 12'd0, 3'd0, 16'd0, 14'd0},
      1'b1, '{STATUS_GRANT, 9'd0, 10'd0, 14'd0}},
    '{ROW_REQ, CFG_RADIX, 7'd0,
      '{OP_ARRIVAL, 12'd0, 12'd0, 3'd0, 12'd0, 3'd0, 16'd0, 14'd0},
      1'b1, '{STATUS_BUSY, 9'd0, 10'd0, 14'd0}},
    // release frees channel 0, so the next arrival gets it again
    '{ROW_REQ, CFG_RADIX, 7'd0,
      '{OP_RELEASE, 12'd0, 12'd0, 3'd0, 12'd0, 3'd0, 16'd0, 14'd0},
      1'b0, NO_PIN},
    '{ROW_REQ, CFG_RADIX, 7'd0,
      '{OP_ARRIVAL, 12'd0, 12'd0, 3'd0, 12'd0, 3'd0, 16'd0, 14'd0},
      1'b1, '{STATUS_GRANT, 9'd0, 10'd0, 14'd0}},
    // all fields at their maximum: slot 3, in 3+7, out 3+3, chan 1023*4+6
    '{ROW_REQ, CFG_RADIX, 7'd0,
      '{OP_ARRIVAL, 12'd4095, 12'd4095, 3'd7, 12'd4095, 3'd5, 16'hFFFF, 14'h3FFF},
      1'b1, '{STATUS_GRANT, 9'd10, 10'd6, 14'd4098}},
    '{ROW_REQ, CFG_RADIX, 7'd0,
      '{OP_ARRIVAL, 12'd4095, 12'd4095, 3'd7, 12'd0, 3'd0, 16'd0, 14'd0},
      1'b1, '{STATUS_BUSY, 9'd10, 10'd6, 14'd4098}},
    // release of a free channel at the top of the map, then of 4098
    '{ROW_REQ, CFG_RADIX, 7'd0,
      '{OP_RELEASE, 12'd4095, 12'd4095, 3'd7, 12'd4095, 3'd7, 16'hFFFF, 14'h3FFF},
      1'b0, NO_PIN},
    '{ROW_REQ, CFG_RADIX, 7'd0,
      '{OP_RELEASE, 12'd0, 12'd0, 3'd0, 12'd0, 3'd0, 16'd0, 14'd4098},
      1'b0, NO_PIN},
    '{ROW_REQ, CFG_RADIX, 7'd0,
      '{OP_ARRIVAL, 12'd4095, 12'd4095, 3'd7, 12'd1, 3'd1, 16'd1, 14'd0},
      1'b0, NO_PIN},
    // bundle count beyond its nominal range is still echoed
    '{ROW_REQ, CFG_RADIX, 7'd0,
      '{OP_ARRIVAL, 12'd5, 12'd9, 3'd2, 12'd2730, 3'd7, 16'h5A5A, 14'd0},
      1'b0, NO_PIN},
    // radix 1, eight transmitters, group 64: high racks run past the map
    '{ROW_CFG, CFG_RADIX, 7'd1, NO_REQ, 1'b0, NO_PIN},
    '{ROW_CFG, CFG_NTX,   7'd8, NO_REQ, 1'b0, NO_PIN},
    '{ROW_CFG, CFG_GROUP, 7'd64, NO_REQ, 1'b0, NO_PIN},
    '{ROW_REQ, CFG_RADIX, 7'd0,
      '{OP_ARRIVAL, 12'd4095, 12'd4095, 3'd7, 12'd0, 3'd0, 16'd0, 14'd0},
      1'b1, '{STATUS_RANGE, 9'd7, 10'd0, 14'd16376}},
    // last reachable channel inside the map (16376), then the first one past it
    '{ROW_REQ, CFG_RADIX, 7'd0,
      '{OP_ARRIVAL, 12'd2047, 12'd3, 3'd0, 12'd0, 3'd0, 16'd0, 14'd0},
      1'b0, NO_PIN},
    '{ROW_REQ, CFG_RADIX, 7'd0,
      '{OP_ARRIVAL, 12'd2048, 12'd3, 3'd0, 12'd0, 3'd0, 16'd0, 14'd0},
      1'b0, NO_PIN},
    // zero registers behave as one
    '{ROW_CFG, CFG_RADIX, 7'd0, NO_REQ, 1'b0, NO_PIN},
    '{ROW_CFG, CFG_NTX,   7'd0, NO_REQ, 1'b0, NO_PIN},
    '{ROW_CFG, CFG_GROUP, 7'd0, NO_REQ, 1'b0, NO_PIN},
    '{ROW_REQ, CFG_RADIX, 7'd0,
      '{OP_ARRIVAL, 12'd100, 12'd7, 3'd3, 12'd0, 3'd0, 16'd0, 14'd0},
      1'b0, NO_PIN},
    // oversized registers: ports wider than their fields get masked
    '{ROW_CFG, CFG_RADIX, 7'd127, NO_REQ, 1'b0, NO_PIN},
    '{ROW_CFG, CFG_NTX,   7'd127, NO_REQ, 1'b0, NO_PIN},
    '{ROW_CFG, CFG_GROUP, 7'd1, NO_REQ, 1'b0, NO_PIN},
    '{ROW_CFG, CFG_SPARE, 7'h55, NO_REQ, 1'b0, NO_PIN},
    '{ROW_REQ, CFG_RADIX, 7'd0,
      '{OP_ARRIVAL, 12'd126, 12'd126, 3'd7, 12'd0, 3'd0, 16'd0, 14'd0},
      1'b0, NO_PIN},
    '{ROW_REQ, CFG_RADIX, 7'd0,
      '{OP_ARRIVAL, 12'd4094, 12'd4095, 3'd5, 12'd0, 3'd0, 16'd0, 14'd0},
      1'b0, NO_PIN},
    // top of the nominal ranges: input port reaches 511
    '{ROW_CFG, CFG_RADIX, 7'd64, NO_REQ, 1'b0, NO_PIN},
    '{ROW_CFG, CFG_NTX,   7'd8, NO_REQ, 1'b0, NO_PIN},
    '{ROW_CFG, CFG_GROUP, 7'd64, NO_REQ, 1'b0, NO_PIN},
    '{ROW_REQ, CFG_RADIX, 7'd0,
      '{OP_ARRIVAL, 12'd4095, 12'd4095, 3'd7, 12'd0, 3'd0, 16'd0, 14'd0},
      1'b0, NO_PIN},
    '{ROW_REQ, CFG_RADIX, 7'd0,
      '{OP_ARRIVAL, 12'd63, 12'd63, 3'd7, 12'd0, 3'd0, 16'd0, 14'd0},
      1'b0, NO_PIN}
  };

  // DUT ports
  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic                  opcode_i;
  logic [RACK_W-1:0]     source_rack_i;
  logic [RACK_W-1:0]     dest_rack_i;
  logic [TX_W-1:0]       transmitter_i;
  logic [RACK_W-1:0]     group_rack_index_i;
  logic [OCNT_W-1:0]     optical_count_i;
  logic [APN_W-1:0]      app_packet_number_i;
  logic [REL_W-1:0]      release_channel_i;
  logic                  res_valid_o;
  logic [STATUS_W-1:0]   status_o;
  logic [IN_PORT_W-1:0]  input_port_o;
  logic [OUT_PORT_W-1:0] output_port_o;
  logic [CHAN_W-1:0]     channel_index_o;
  logic [RACK_W-1:0]     ack_source_rack_o;
  logic [RACK_W-1:0]     ack_dest_rack_o;
  logic [TX_W-1:0]       ack_transmitter_o;
  logic [RACK_W-1:0]     ack_group_rack_index_o;
  logic [OCNT_W-1:0]     ack_optical_count_o;
  logic [APN_W-1:0]      ack_app_packet_number_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // pinned expectation that goes with the request currently on the port
  logic                  pin_active;
  pin_t                  pin_fields;

  // predictor copy of the busy map and the registers
  bit                    chan_busy [CHANNELS];
  logic [RADIX_W-1:0]    radix_reg = RADIX_RST;
  logic [NTX_W-1:0]      ntx_reg   = NTX_RST;
  logic [GROUP_W-1:0]    group_reg = GROUP_RST;

  ack_t                  pending_acks [$];
  logic [CHAN_W-1:0]     granted_channels [$];

  int unsigned           fail_count;
  int unsigned           n_arrival, n_release, n_grant, n_busy, n_range;
  int unsigned           n_results, n_cfg_writes;

  optical_switch_slot_contention i_dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .start_i                 (start_i),
    .busy_o                  (busy_o),
    .opcode_i                (opcode_i),
    .source_rack_i           (source_rack_i),
    .dest_rack_i             (dest_rack_i),
    .transmitter_i           (transmitter_i),
    .group_rack_index_i      (group_rack_index_i),
    .optical_count_i         (optical_count_i),
    .app_packet_number_i     (app_packet_number_i),
    .release_channel_i       (release_channel_i),
    .res_valid_o             (res_valid_o),
    .status_o                (status_o),
    .input_port_o            (input_port_o),
    .output_port_o           (output_port_o),
    .channel_index_o         (channel_index_o),
    .ack_source_rack_o       (ack_source_rack_o),
    .ack_dest_rack_o         (ack_dest_rack_o),
    .ack_transmitter_o       (ack_transmitter_o),
    .ack_group_rack_index_o  (ack_group_rack_index_o),
    .ack_optical_count_o     (ack_optical_count_o),
    .ack_app_packet_number_o (ack_app_packet_number_o),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_ready_o             (cfg_ready_o),
    .cfg_index_i             (cfg_index_i),
    .cfg_data_i              (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Contention decision for one arrival: derive ports and channel, then
  // test-and-set the busy bit. Registers at zero count as one.
  function automatic ack_t resolve_arrival(input req_t r);
    ack_t        a;
    int unsigned radix, ntx, grp, slot, in_p, out_p, chan;
    radix = (radix_reg == '0) ? 1 : radix_reg;
    ntx   = (ntx_reg == '0) ? 1 : ntx_reg;
    grp   = (group_reg == '0) ? 1 : group_reg;
    slot  = r.source_rack % radix;
    in_p  = slot * ntx + r.transmitter;
    out_p = (r.dest_rack % radix) * ntx + slot / grp;
    // the map test uses the full channel; only the report is masked
    chan  = (r.source_rack / radix) * radix * ntx + out_p;
    if (chan >= CHANNELS) begin
      a.status = STATUS_RANGE;
    end else if (chan_busy[chan]) begin
      a.status = STATUS_BUSY;
    end else begin
      chan_busy[chan] = 1'b1;
      a.status = STATUS_GRANT;
    end
    a.input_port        = IN_PORT_W'(in_p);
    a.output_port       = OUT_PORT_W'(out_p);
    a.channel           = CHAN_W'(chan);
    a.source_rack       = r.source_rack;
    a.dest_rack         = r.dest_rack;
    a.transmitter       = r.transmitter;
    a.group_rack_index  = r.group_rack_index;
    a.optical_count     = r.optical_count;
    a.app_packet_number = r.app_packet_number;
    return a;
  endfunction

  function automatic void store_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_RADIX: radix_reg = RADIX_W'(data);
      CFG_NTX:   ntx_reg   = NTX_W'(data);
      CFG_GROUP: group_reg = GROUP_W'(data);
      default: ;
    endcase
  endfunction

  task automatic check_ack(input ack_t want, input ack_t got);
    if (got.status !== want.status) begin
      $error("status_o: expected %0d, actual %0d", want.status, got.status);
      fail_count++;
    end
    if (got.input_port !== want.input_port) begin
      $error("input_port_o: expected %0d, actual %0d", want.input_port, got.input_port);
      fail_count++;
    end
    if (got.output_port !== want.output_port) begin
      $error("output_port_o: expected %0d, actual %0d", want.output_port, got.output_port);
      fail_count++;
    end
    if (got.channel !== want.channel) begin
      $error("channel_index_o: expected %0d, actual %0d", want.channel, got.channel);
      fail_count++;
    end
    if (got.source_rack !== want.source_rack) begin
      $error("ack_source_rack_o: expected %0d, actual %0d",
             want.source_rack, got.source_rack);
      fail_count++;
    end
    if (got.dest_rack !== want.dest_rack) begin
      $error("ack_dest_rack_o: expected %0d, actual %0d", want.dest_rack, got.dest_rack);
      fail_count++;
    end
    if (got.transmitter !== want.transmitter) begin
      $error("ack_transmitter_o: expected %0d, actual %0d",
             want.transmitter, got.transmitter);
      fail_count++;
    end
    if (got.group_rack_index !== want.group_rack_index) begin
      $error("ack_group_rack_index_o: expected %0d, actual %0d",
             want.group_rack_index, got.group_rack_index);
      fail_count++;
    end
    if (got.optical_count !== want.optical_count) begin
      $error("ack_optical_count_o: expected %0d, actual %0d",
             want.optical_count, got.optical_count);
      fail_count++;
    end
    if (got.app_packet_number !== want.app_packet_number) begin
      $error("ack_app_packet_number_o: expected %0d, actual %0d",
             want.app_packet_number, got.app_packet_number);
      fail_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: one process watches results, register writes and accepted
  // requests at each rising edge. Results are checked before the request of
  // the same edge is predicted, since a result always belongs to an older one.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    ack_t seen;
    ack_t want;
    req_t taken;
    if (rst_ni === 1'b1) begin
      if (res_valid_o === 1'b1) begin
        seen.status            = status_o;
        seen.input_port        = input_port_o;
        seen.output_port       = output_port_o;
        seen.channel           = channel_index_o;
        seen.source_rack       = ack_source_rack_o;
        seen.dest_rack         = ack_dest_rack_o;
        seen.transmitter       = ack_transmitter_o;
        seen.group_rack_index  = ack_group_rack_index_o;
        seen.optical_count     = ack_optical_count_o;
        seen.app_packet_number = ack_app_packet_number_o;
        n_results++;
        if (pending_acks.size() == 0) begin
          $error("result with no pending arrival: status %0d channel %0d",
                 status_o, channel_index_o);
          fail_count++;
        end else begin
          want = pending_acks.pop_front();
          check_ack(want, seen);
        end
      end

      if (cfg_valid_i === 1'b1 && cfg_ready_o === 1'b1) begin
        store_register(cfg_index_i, cfg_data_i);
        n_cfg_writes++;
      end

      if (start_i === 1'b1 && busy_o === 1'b0) begin
        taken.opcode            = opcode_i;
        taken.source_rack       = source_rack_i;
        taken.dest_rack         = dest_rack_i;
        taken.transmitter       = transmitter_i;
        taken.group_rack_index  = group_rack_index_i;
        taken.optical_count     = optical_count_i;
        taken.app_packet_number = app_packet_number_i;
        taken.release_channel   = release_channel_i;
        if (taken.opcode == OP_RELEASE) begin
          // release of a free channel leaves it free; no result comes back
          n_release++;
          if (taken.release_channel < CHANNELS) chan_busy[taken.release_channel] = 1'b0;
        end else begin
          n_arrival++;
          want = resolve_arrival(taken);
          if (pin_active) begin
            want.status      = pin_fields.status;
            want.input_port  = pin_fields.input_port;
            want.output_port = pin_fields.output_port;
            want.channel     = pin_fields.channel;
          end
          case (want.status)
            STATUS_GRANT: begin
              n_grant++;
              granted_channels.push_back(want.channel);
            end
            STATUS_BUSY:  n_busy++;
            default:      n_range++;
          endcase
          pending_acks.push_back(want);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------

  // Put one request on the port after an idle burst of `gap` cycles and
  // hold it until the block takes it. With no gap start_i stays high.
  task automatic send_request(input req_t r, input logic pinned, input pin_t pin,
                              input int unsigned gap);
    if (gap != 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    opcode_i            <= r.opcode;
    source_rack_i       <= r.source_rack;
    dest_rack_i         <= r.dest_rack;
    transmitter_i       <= r.transmitter;
    group_rack_index_i  <= r.group_rack_index;
    optical_count_i     <= r.optical_count;
    app_packet_number_i <= r.app_packet_number;
    release_channel_i   <= r.release_channel;
    pin_active          <= pinned;
    pin_fields          <= pin;
    start_i             <= 1'b1;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
  endtask

  // Drop start_i and wait until every arrival has answered, then let a
  // trailing release finish before registers change.
  task automatic settle_block();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_acks.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly arrivals from a small rack pool so channels collide, and releases
  // of channels granted earlier; the rest is full-range noise.
  function automatic req_t random_request();
    req_t        r;
    int unsigned k;
    r.opcode            = ($urandom_range(0, 99) < 60) ? OP_ARRIVAL : OP_RELEASE;
    r.source_rack       = ($urandom_range(0, 99) < 60) ? RACK_W'($urandom_range(0, 15))
                                                       : RACK_W'($urandom());
    r.dest_rack         = ($urandom_range(0, 99) < 60) ? RACK_W'($urandom_range(0, 15))
                                                       : RACK_W'($urandom());
    r.transmitter       = TX_W'($urandom());
    r.group_rack_index  = RACK_W'($urandom());
    r.optical_count     = ($urandom_range(0, 9) == 0) ? OCNT_W'($urandom_range(6, 7))
                                                      : OCNT_W'($urandom_range(0, 5));
    r.app_packet_number = APN_W'($urandom());
    r.release_channel   = REL_W'($urandom());
    if (r.opcode == OP_RELEASE && granted_channels.size() != 0 &&
        $urandom_range(0, 99) < 85) begin
      k = $urandom_range(0, granted_channels.size() - 1);
      r.release_channel = granted_channels[k];
      granted_channels.delete(k);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic                  last_was_cfg;
    logic [CFG_DATA_W-1:0] rdx, ntx, grp;
    int unsigned           gap;

    // every input known from time zero while reset is held low
    rst_ni              = 1'b0;
    start_i             = 1'b0;
    opcode_i            = OP_ARRIVAL;
    source_rack_i       = '0;
    dest_rack_i         = '0;
    transmitter_i       = '0;
    group_rack_index_i  = '0;
    optical_count_i     = '0;
    app_packet_number_i = '0;
    release_channel_i   = '0;
    cfg_valid_i         = 1'b0;
    cfg_index_i         = CFG_RADIX;
    cfg_data_i          = '0;
    pin_active          = 1'b0;
    pin_fields          = NO_PIN;
    fail_count          = 0;
    last_was_cfg        = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table, back to back; the first request waits out the
    // clearing sweep through busy_o
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        if (!last_was_cfg) settle_block();
        write_register(DIRECTED[i].cfg_index, DIRECTED[i].cfg_data);
        last_was_cfg = 1'b1;
      end else begin
        send_request(DIRECTED[i].req, DIRECTED[i].pinned, DIRECTED[i].pin, 0);
        last_was_cfg = 1'b0;
      end
    end

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin rdx = 7'd4;  ntx = 7'd1;   grp = 7'd1;   end  // reset values
        1: begin rdx = 7'd1;  ntx = 7'd1;   grp = 7'd1;   end  // minimum
        2: begin rdx = 7'd64; ntx = 7'd8;   grp = 7'd64;  end  // maximum in range
        3: begin rdx = 7'd8;  ntx = 7'd4;   grp = 7'd2;   end
        5: begin rdx = 7'd0;  ntx = 7'd0;   grp = 7'd0;   end  // zero as one
        6: begin rdx = 7'd127; ntx = 7'd127; grp = 7'd127; end // past the ranges
        default: begin
          rdx = CFG_DATA_W'($urandom_range(1, 64));
          ntx = CFG_DATA_W'($urandom_range(1, 8));
          grp = CFG_DATA_W'($urandom_range(1, 64));
        end
      endcase
      settle_block();
      write_register(CFG_RADIX, rdx);
      write_register(CFG_NTX, ntx);
      write_register(CFG_GROUP, grp);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // idle bursts everywhere except the final phase
        if (p == PHASES - 1 || $urandom_range(0, 1) == 0) gap = 0;
        else gap = $urandom_range(1, 15);
        send_request(random_request(), 1'b0, NO_PIN, gap);
      end
    end

    settle_block();
    $display("covered %0d arrivals (%0d granted, %0d busy, %0d out of range), %0d releases",
             n_arrival, n_grant, n_busy, n_range, n_release);
    $display("under %0d register writes; %0d results checked", n_cfg_writes, n_results);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding",
             CYCLE_LIMIT, pending_acks.size());
    $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/osc_pkg.sv
hdl/osc_div_unit.sv
hdl/osc_chan_mem.sv
hdl/optical_switch_slot_contention.sv
hdl/osc_checker.sv
tb/sv/testbench.sv
